/* hw/rtl/bpms_pkg.sv */
// Shared types, constants and helpers for the bus poll master/slave block.
// Used by bpms_ram users, bpms_ctrl, bpms_dp and the top level.
package bpms_pkg;

  localparam int unsigned MAX_SLAVES = 8;
  localparam int unsigned IDX_W      = (MAX_SLAVES > 1) ? $clog2(MAX_SLAVES) : 1;
  localparam int unsigned CNT_W      = $clog2(MAX_SLAVES + 1);
  localparam int unsigned ADDR_W     = 48;
  localparam int unsigned TIME_W     = 16;
  localparam int unsigned CFG_IDX_W  = 3;

  localparam logic [TIME_W-1:0] TIME_MAX          = '1;
  localparam logic [TIME_W-1:0] POLL_INTERVAL_RST = TIME_W'(1000);
  localparam logic [TIME_W-1:0] DISC_WINDOW_RST   = TIME_W'(2000);
  localparam logic [TIME_W-1:0] REPLY_TIMEOUT_RST = TIME_W'(200);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GATEWAY_ROLE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDRESS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POLL_INTERVAL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DISC_WINDOW   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REPLY_TIMEOUT = 3'd4;

  typedef enum logic [2:0] {
    ACT_TICK     = 3'd0,
    ACT_HELLO    = 3'd1,
    ACT_READINGS = 3'd2,
    ACT_DISCOVER = 3'd3,
    ACT_POLL     = 3'd4,
    ACT_OTHER    = 3'd5
  } action_e;

  typedef enum logic [2:0] {
    KIND_NONE     = 3'd0,
    KIND_DISCOVER = 3'd1,
    KIND_POLL     = 3'd2,
    KIND_HELLO    = 3'd3,
    KIND_READINGS = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_DISCOVER = 2'd1,
    PH_POLLING  = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_TICK,
    ST_SEARCH,
    ST_ADD,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic [2:0]        action;
    logic [ADDR_W-1:0] peer_address;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        send_kind;
    logic [ADDR_W-1:0] send_address;
    logic              readings_accepted;
    logic              slave_added;
    logic              reply_missed;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic srch_first;
    logic srch_next;
    logic exec_tick;
    logic exec_msg;
    logic add;
    logic finish;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_tick;
    logic hello_ok;
    logic cnt_zero;
    logic srch_hit;
    logic srch_last;
  } ctrl_sts_t;

  function automatic logic [TIME_W-1:0] sat_inc(input logic [TIME_W-1:0] v);
    sat_inc = (v == TIME_MAX) ? TIME_MAX : v + TIME_W'(1);
  endfunction

endpackage

/* hw/rtl/bpms_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bpms_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                 wdata_i,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr_i,
  output logic [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* hw/rtl/bpms_ctrl.sv */
// Sequencer for the bus poll block: steps each event through decode,
// table search/insert or tick evaluation, and the result register. Uses bpms_pkg.
module bpms_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  bpms_pkg::ctrl_sts_t sts_i,
  output bpms_pkg::ctrl_cmd_t cmd_o
);

  bpms_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == bpms_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      bpms_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = bpms_pkg::ST_DECODE;
      end
      bpms_pkg::ST_DECODE: begin
        if (sts_i.is_tick) begin
          state_d = bpms_pkg::ST_TICK;
        end else if (sts_i.hello_ok) begin
          state_d = sts_i.cnt_zero ? bpms_pkg::ST_ADD : bpms_pkg::ST_SEARCH;
        end else begin
          state_d = bpms_pkg::ST_FINISH;
        end
      end
      bpms_pkg::ST_TICK: state_d = bpms_pkg::ST_FINISH;
      bpms_pkg::ST_SEARCH: begin
        if (sts_i.srch_hit) begin
          state_d = bpms_pkg::ST_FINISH;
        end else if (sts_i.srch_last) begin
          state_d = bpms_pkg::ST_ADD;
        end
      end
      bpms_pkg::ST_ADD: state_d = bpms_pkg::ST_FINISH;
      bpms_pkg::ST_FINISH: begin
        if (out_free) state_d = bpms_pkg::ST_IDLE;
      end
      default: state_d = bpms_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      bpms_pkg::ST_IDLE:   cmd_o.load = in_valid_i;
      bpms_pkg::ST_DECODE: begin
        if (!sts_i.is_tick && sts_i.hello_ok) begin
          cmd_o.srch_first = 1'b1;
        end else if (!sts_i.is_tick) begin
          cmd_o.exec_msg = 1'b1;
        end
      end
      bpms_pkg::ST_TICK:   cmd_o.exec_tick = 1'b1;
      bpms_pkg::ST_SEARCH: cmd_o.srch_next = !sts_i.srch_hit && !sts_i.srch_last;
      bpms_pkg::ST_ADD:    cmd_o.add = 1'b1;
      bpms_pkg::ST_FINISH: cmd_o.finish = out_free;
      default:             cmd_o = '0;
    endcase
  end

  // Set on result load, drop after the transfer
  assign out_valid_d = cmd_o.finish ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bpms_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

/* hw/rtl/bpms_dp.sv */
// Datapath for the bus poll block: configuration registers, master schedule
// counters, slave table (bpms_ram) and result register. Uses bpms_pkg.
module bpms_dp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [2:0]            cfg_idx_i,
  input  logic [47:0]           cfg_wdata_i,
  input  bpms_pkg::in_item_t    in_item_i,
  output bpms_pkg::out_item_t   out_item_o,
  input  bpms_pkg::ctrl_cmd_t   cmd_i,
  output bpms_pkg::ctrl_sts_t   sts_o
);

  localparam int unsigned IW = bpms_pkg::IDX_W;
  localparam int unsigned CW = bpms_pkg::CNT_W;
  localparam int unsigned TW = bpms_pkg::TIME_W;
  localparam int unsigned AW = bpms_pkg::ADDR_W;

  // Configuration
  logic          role_q;
  logic [AW-1:0] own_addr_q;
  logic [TW-1:0] poll_int_q, disc_win_q, reply_to_q;

  // Schedule state
  bpms_pkg::phase_e phase_q, phase_d;
  logic [TW-1:0]    elapsed_q, elapsed_d;
  logic [TW-1:0]    since_q, since_d;
  logic [IW-1:0]    pidx_q, pidx_d;
  logic             seen_q, seen_d;
  logic [CW-1:0]    count_q, count_d;
  logic             last_role_q;

  // Current item, search index, result
  logic [2:0]          action_q;
  logic [AW-1:0]       peer_q;
  logic [IW-1:0]       sidx_q, sidx_d;
  bpms_pkg::out_item_t res_q, res_d;
  bpms_pkg::out_item_t out_q;

  logic [IW-1:0] raddr, sidx_inc;
  logic [AW-1:0] rdata;
  logic          role_change;
  logic [TW-1:0] el_inc, sp_inc;

  assign sidx_inc    = sidx_q + IW'(1);
  assign raddr       = cmd_i.srch_next  ? sidx_inc :
                       cmd_i.srch_first ? '0       : pidx_q;
  assign role_change = role_q != last_role_q;
  assign el_inc      = bpms_pkg::sat_inc(elapsed_q);
  assign sp_inc      = bpms_pkg::sat_inc(since_q);

  bpms_ram #(
    .WIDTH (AW),
    .DEPTH (bpms_pkg::MAX_SLAVES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (cmd_i.add),
    .waddr_i (count_q[IW-1:0]),
    .wdata_i (peer_q),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign sts_o.is_tick   = action_q == bpms_pkg::ACT_TICK;
  assign sts_o.hello_ok  = role_q && (action_q == bpms_pkg::ACT_HELLO) &&
                           (phase_q == bpms_pkg::PH_DISCOVER) &&
                           (count_q < CW'(bpms_pkg::MAX_SLAVES));
  assign sts_o.cnt_zero  = count_q == '0;
  assign sts_o.srch_hit  = rdata == peer_q;
  assign sts_o.srch_last = {1'b0, sidx_q} + (IW+1)'(1) == (IW+1)'(count_q);

  assign out_item_o = out_q;

  always_comb begin
    phase_d   = phase_q;
    elapsed_d = elapsed_q;
    since_d   = since_q;
    pidx_d    = pidx_q;
    seen_d    = seen_q;
    count_d   = count_q;
    sidx_d    = sidx_q;
    res_d     = res_q;

    if (cmd_i.load) begin
      res_d = '0;
      // Role change empties the table and restarts the schedule
      if (role_change) begin
        count_d = '0;
        phase_d = bpms_pkg::PH_IDLE;
        since_d = bpms_pkg::TIME_MAX;
        seen_d  = 1'b0;
        pidx_d  = '0;
      end
    end

    if (cmd_i.srch_first) sidx_d = '0;
    if (cmd_i.srch_next)  sidx_d = sidx_inc;

    if (cmd_i.add) begin
      count_d           = count_q + CW'(1);
      res_d.slave_added = 1'b1;
    end

    if (cmd_i.exec_msg) begin
      if (role_q) begin
        if (action_q == bpms_pkg::ACT_READINGS && phase_q == bpms_pkg::PH_POLLING) begin
          seen_d                  = 1'b1;
          res_d.readings_accepted = 1'b1;
        end
      end else if (action_q == bpms_pkg::ACT_DISCOVER) begin
        res_d.send_kind    = bpms_pkg::KIND_HELLO;
        res_d.send_address = own_addr_q;
      end else if (action_q == bpms_pkg::ACT_POLL && peer_q == own_addr_q) begin
        res_d.send_kind    = bpms_pkg::KIND_READINGS;
        res_d.send_address = own_addr_q;
      end
    end

    if (cmd_i.exec_tick) begin
      elapsed_d = el_inc;
      since_d   = sp_inc;
      if (role_q) begin
        case (phase_q)
          bpms_pkg::PH_IDLE: begin
            if (count_q == '0) begin
              res_d.send_kind = bpms_pkg::KIND_DISCOVER;
              phase_d         = bpms_pkg::PH_DISCOVER;
              elapsed_d       = '0;
            end else if (sp_inc >= poll_int_q) begin
              res_d.send_kind    = bpms_pkg::KIND_POLL;
              res_d.send_address = rdata;
              seen_d             = 1'b0;
              phase_d            = bpms_pkg::PH_POLLING;
              elapsed_d          = '0;
              since_d            = '0;
            end
          end
          bpms_pkg::PH_DISCOVER: begin
            if (el_inc >= disc_win_q) phase_d = bpms_pkg::PH_IDLE;
          end
          bpms_pkg::PH_POLLING: begin
            if (el_inc >= reply_to_q) begin
              res_d.reply_missed = !seen_q;
              // Advance round robin, wrap at the table fill
              if (count_q == '0 || ({1'b0, pidx_q} + (IW+1)'(1)) == (IW+1)'(count_q)) begin
                pidx_d = '0;
              end else begin
                pidx_d = pidx_q + IW'(1);
              end
              phase_d = bpms_pkg::PH_IDLE;
            end
          end
          default: phase_d = bpms_pkg::PH_IDLE;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      role_q      <= 1'b0;
      own_addr_q  <= '0;
      poll_int_q  <= bpms_pkg::POLL_INTERVAL_RST;
      disc_win_q  <= bpms_pkg::DISC_WINDOW_RST;
      reply_to_q  <= bpms_pkg::REPLY_TIMEOUT_RST;
      phase_q     <= bpms_pkg::PH_IDLE;
      elapsed_q   <= '0;
      since_q     <= bpms_pkg::TIME_MAX;
      pidx_q      <= '0;
      seen_q      <= 1'b0;
      count_q     <= '0;
      last_role_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          bpms_pkg::CFG_GATEWAY_ROLE:  role_q     <= cfg_wdata_i[0];
          bpms_pkg::CFG_OWN_ADDRESS:   own_addr_q <= cfg_wdata_i;
          bpms_pkg::CFG_POLL_INTERVAL: poll_int_q <= cfg_wdata_i[TW-1:0];
          bpms_pkg::CFG_DISC_WINDOW:   disc_win_q <= cfg_wdata_i[TW-1:0];
          bpms_pkg::CFG_REPLY_TIMEOUT: reply_to_q <= cfg_wdata_i[TW-1:0];
          default: ;
        endcase
      end
      if (cmd_i.load) last_role_q <= role_q;
      phase_q   <= phase_d;
      elapsed_q <= elapsed_d;
      since_q   <= since_d;
      pidx_q    <= pidx_d;
      seen_q    <= seen_d;
      count_q   <= count_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      action_q <= in_item_i.action;
      peer_q   <= in_item_i.peer_address;
    end
    sidx_q <= sidx_d;
    res_q  <= res_d;
    if (cmd_i.finish) out_q <= res_q;
  end

endmodule

/* hw/rtl/bus_poll_master_slave_protocol.sv */
// Top level of the bus poll master/slave block.
// Instantiates bpms_ctrl and bpms_dp; uses bpms_pkg.
//
// Usage:
//   in channel  (in_valid_i/in_ready_o/in_item_i): one event per transfer, a
//     millisecond tick or a classified received message with its address.
//   out channel (out_valid_o/out_ready_i/out_item_o): exactly one result per
//     event: the frame to send plus readings/new-slave/missed-reply flags.
//   cfg port (cfg_we_i/cfg_idx_i/cfg_wdata_i): write-only registers 0..4
//     (role, own address, poll interval, discover window, reply timeout);
//     write them only while no event is in flight.
// A message passes the decode and finish states, a tick decode, tick and finish;
//   a hello taken for the table passes decode, a search of the slave table
//   unless it is empty, add unless the address is found, and finish. The search
//   walks the table one entry per cycle through its single read port. Events are
//   handled one at a time by the sequencer: a new one is taken only in idle.
// Reset: schedule idle, table empty, role slave, timing registers at
//   1000/2000/200 ticks. The table RAM is not cleared; the fill count guards it.
// Stall: the result sits in an output register; the next event is taken
//   meanwhile and its result waits until the register is free.
module bus_poll_master_slave_protocol (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [47:0]         cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  bpms_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output bpms_pkg::out_item_t out_item_o
);

  bpms_pkg::ctrl_cmd_t cmd;
  bpms_pkg::ctrl_sts_t sts;

  bpms_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bpms_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_item_i   (in_item_i),
    .out_item_o  (out_item_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

/* sim/bpms_poll_checker.sv */
// Result checker for bus_poll_master_slave_protocol: follows register writes and
// input transfers, predicts each result and compares the output transfers in order.
// Depends on bpms_pkg for the item types, codes and table size.
module bpms_poll_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [47:0]         cfg_wdata_i,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  bpms_pkg::in_item_t  in_item_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  bpms_pkg::out_item_t out_item_i,
  output int                  fail_count_o,
  output int                  pending_o
);
  import bpms_pkg::*;

  localparam int TICK_SAT = 65535;

  // register copies
  logic        gw_role;
  logic [47:0] own_addr;
  int          poll_ivl;
  int          disc_win;
  int          reply_tmo;

  // schedule and table copies
  phase_e      phase;
  int          phase_ticks;
  int          since_poll;
  int          poll_idx;
  int          fill;
  logic        seen;
  logic        prev_role;
  logic [47:0] slave_addr [MAX_SLAVES];

  out_item_t   expected_results [$];
  int          fail_total;

  function automatic out_item_t predict_event(input in_item_t ev);
    out_item_t r;
    logic      known;
    r = '0;
    known = 1'b0;
    // a role change empties the table and restarts the schedule
    if (gw_role != prev_role) begin
      fill       = 0;
      phase      = PH_IDLE;
      since_poll = TICK_SAT;
      seen       = 1'b0;
      poll_idx   = 0;
    end
    prev_role = gw_role;

    if (ev.action == ACT_TICK) begin
      if (phase_ticks < TICK_SAT) phase_ticks++;
      if (since_poll < TICK_SAT) since_poll++;
      if (gw_role) begin
        case (phase)
          PH_IDLE: begin
            if (fill == 0) begin
              r.send_kind = KIND_DISCOVER;
              phase       = PH_DISCOVER;
              phase_ticks = 0;
            end else if (since_poll >= poll_ivl) begin
              r.send_kind    = KIND_POLL;
              r.send_address = slave_addr[poll_idx % MAX_SLAVES];
              seen           = 1'b0;
              phase          = PH_POLLING;
              phase_ticks    = 0;
              since_poll     = 0;
            end
          end
          PH_DISCOVER: begin
            if (phase_ticks >= disc_win) phase = PH_IDLE;
          end
          PH_POLLING: begin
            if (phase_ticks >= reply_tmo) begin
              if (!seen) r.reply_missed = 1'b1;
              poll_idx = (fill != 0) ? (poll_idx + 1) % fill : 0;
              phase    = PH_IDLE;
            end
          end
          default: phase = PH_IDLE;
        endcase
      end
    end else if (gw_role) begin
      if (ev.action == ACT_HELLO && phase == PH_DISCOVER && fill < MAX_SLAVES) begin
        for (int i = 0; i < fill; i++)
          if (slave_addr[i] == ev.peer_address) known = 1'b1;
        if (!known) begin
          slave_addr[fill] = ev.peer_address;
          fill++;
          r.slave_added = 1'b1;
        end
      end else if (ev.action == ACT_READINGS && phase == PH_POLLING) begin
        seen                = 1'b1;
        r.readings_accepted = 1'b1;
      end
    end else begin
      if (ev.action == ACT_DISCOVER) begin
        r.send_kind    = KIND_HELLO;
        r.send_address = own_addr;
      end else if (ev.action == ACT_POLL && ev.peer_address == own_addr) begin
        r.send_kind    = KIND_READINGS;
        r.send_address = own_addr;
      end
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [47:0] exp,
                             input logic [47:0] act);
    if (act !== exp) begin
      fail_total++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp, act);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      gw_role     = 1'b0;
      own_addr    = '0;
      poll_ivl    = 1000;
      disc_win    = 2000;
      reply_tmo   = 200;
      phase       = PH_IDLE;
      phase_ticks = 0;
      since_poll  = TICK_SAT;
      poll_idx    = 0;
      fill        = 0;
      seen        = 1'b0;
      prev_role   = 1'b0;
      fail_total  = 0;
      expected_results.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_GATEWAY_ROLE:  gw_role   = cfg_wdata_i[0];
          CFG_OWN_ADDRESS:   own_addr  = cfg_wdata_i;
          CFG_POLL_INTERVAL: poll_ivl  = int'(cfg_wdata_i[15:0]);
          CFG_DISC_WINDOW:   disc_win  = int'(cfg_wdata_i[15:0]);
          CFG_REPLY_TIMEOUT: reply_tmo = int'(cfg_wdata_i[15:0]);
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i)
        expected_results.push_back(predict_event(in_item_i));
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          fail_total++;
          $display("%0t: result with nothing expected, expected none, got %p",
                   $time, out_item_i);
        end else begin
          want = expected_results.pop_front();
          check_field("send_kind", 48'(want.send_kind), 48'(out_item_i.send_kind));
          check_field("send_address", want.send_address, out_item_i.send_address);
          check_field("readings_accepted", 48'(want.readings_accepted),
                      48'(out_item_i.readings_accepted));
          check_field("slave_added", 48'(want.slave_added), 48'(out_item_i.slave_added));
          check_field("reply_missed", 48'(want.reply_missed),
                      48'(out_item_i.reply_missed));
        end
      end
    end
    fail_count_o = fail_total;
    pending_o    = expected_results.size();
  end

endmodule

/* sim/tb_bus_poll_master_slave_protocol.sv */
// Testbench top for bus_poll_master_slave_protocol: drives events and register
// writes with random gaps and stalls; bpms_poll_checker predicts and compares.
// Depends on bpms_pkg, the block and sim/bpms_poll_checker.sv.
module tb_bus_poll_master_slave_protocol;
  import bpms_pkg::*;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [2:0]  cfg_idx_i   = '0;
  logic [47:0] cfg_wdata_i = '0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  in_item_t    in_item_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_item_t   out_item_o;

  int mismatches;
  int pending;
  int burst_left = 0;
  int items_sent = 0;

  bus_poll_master_slave_protocol i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  bpms_poll_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_item_i    (in_item_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_item_i   (out_item_o),
    .fail_count_o (mismatches),
    .pending_o    (pending)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  initial begin
    #1000000;
    $display("bus_poll_master_slave_protocol test failed");
    $finish;
  end

  function automatic logic [47:0] rand48();
    return {16'($urandom), 32'($urandom)};
  endfunction

  function automatic logic [15:0] pick_ticks();
    case ($urandom_range(0, 9))
      0:       return 16'hFFFF;
      1:       return 16'd1;
      2:       return 16'd0;
      default: return 16'($urandom_range(1, 6));
    endcase
  endfunction

  // Offer one event; bursts of transfers are separated by random gaps.
  task automatic send_event(input logic [2:0] act, input logic [47:0] peer);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_item_i  <= {act, peer};
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  // Drop valid and wait until every expected result has come out.
  task automatic settle_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (12) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [47:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Receiver: segments of stall patterns, with a long hold-off now and then.
  initial begin : rx_side
    int seg, len, mode, n;
    logic [7:0] pat;
    seg = 0;
    @(posedge rst_ni);
    forever begin
      seg++;
      if (seg % 150 == 20) begin
        @(negedge clk_i);
        out_ready_i <= 1'b0;
        n = 0;
        while (n < 300) begin
          @(negedge clk_i);
          n++;
        end
      end else begin
        len  = $urandom_range(1, 40);
        mode = $urandom_range(0, 3);
        pat  = 8'($urandom);
        for (n = 0; n < len; n++) begin
          @(negedge clk_i);
          case (mode)
            0:       out_ready_i <= 1'b1;
            1:       out_ready_i <= 1'($urandom_range(0, 1));
            2:       out_ready_i <= ($urandom_range(0, 3) == 0);
            default: out_ready_i <= pat[n % 8];
          endcase
        end
      end
    end
  end

  initial begin : stimulus
    logic        role, prev_role;
    logic [47:0] own, peer, addr_a, addr_b;
    logic [2:0]  act;
    logic [47:0] addr_pool [10];
    int          n, pick;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // slave role at reset: answers, ignored messages and unused actions
    own = '1;
    write_reg(CFG_OWN_ADDRESS, own);
    send_event(ACT_TICK, '0);
    send_event(ACT_DISCOVER, '0);
    send_event(ACT_POLL, own);
    send_event(ACT_POLL, '0);
    send_event(ACT_HELLO, own);
    send_event(ACT_READINGS, own);
    send_event(ACT_OTHER, own);
    send_event(3'd6, rand48());
    send_event(3'd7, '1);
    settle_idle();

    // gateway: discover, duplicate hello, window end, polls, reply and miss
    addr_a = rand48();
    addr_b = rand48();
    write_reg(CFG_GATEWAY_ROLE, 48'd1);
    write_reg(CFG_DISC_WINDOW, 48'd2);
    write_reg(CFG_POLL_INTERVAL, 48'd1);
    write_reg(CFG_REPLY_TIMEOUT, 48'd2);
    send_event(ACT_READINGS, addr_a);
    send_event(ACT_TICK, '1);
    send_event(ACT_HELLO, addr_a);
    send_event(ACT_HELLO, addr_a);
    send_event(ACT_HELLO, addr_b);
    send_event(ACT_DISCOVER, '0);
    send_event(ACT_POLL, own);
    send_event(ACT_TICK, '0);
    send_event(ACT_TICK, '0);
    send_event(ACT_HELLO, rand48());
    send_event(ACT_TICK, '0);
    send_event(ACT_READINGS, addr_b);
    send_event(ACT_TICK, '0);
    send_event(ACT_TICK, '0);
    send_event(ACT_TICK, '0);
    send_event(ACT_TICK, '0);
    send_event(ACT_TICK, '0);

    prev_role = 1'b1;
    while (items_sent < 1320) begin
      settle_idle();
      role = ($urandom_range(0, 3) != 0) ? ~prev_role : prev_role;
      prev_role = role;
      case ($urandom_range(0, 3))
        0:       own = '0;
        1:       own = '1;
        default: own = rand48();
      endcase
      write_reg(CFG_GATEWAY_ROLE, {47'b0, role});
      write_reg(CFG_OWN_ADDRESS, own);
      write_reg(CFG_POLL_INTERVAL, {32'b0, pick_ticks()});
      write_reg(CFG_DISC_WINDOW, {32'b0, pick_ticks()});
      write_reg(CFG_REPLY_TIMEOUT, {32'b0, pick_ticks()});
      for (int k = 0; k < 10; k++) addr_pool[k] = rand48();

      // open discovery and feed a burst of hellos, often enough to fill the table
      if (role) begin
        send_event(ACT_TICK, rand48());
        n = $urandom_range(0, 12);
        repeat (n) send_event(ACT_HELLO, addr_pool[$urandom_range(0, 9)]);
      end

      n = $urandom_range(20, 50);
      repeat (n) begin
        pick = $urandom_range(0, 99);
        peer = rand48();
        if (role) begin
          if (pick < 60) act = ACT_TICK;
          else if (pick < 75) act = ACT_READINGS;
          else if (pick < 83) begin
            act  = ACT_HELLO;
            peer = addr_pool[$urandom_range(0, 9)];
          end else if (pick < 88) act = ACT_DISCOVER;
          else if (pick < 93) act = ACT_POLL;
          else act = 3'($urandom_range(0, 7));
        end else begin
          if (pick < 25) act = ACT_TICK;
          else if (pick < 50) act = ACT_DISCOVER;
          else if (pick < 80) begin
            act = ACT_POLL;
            if (pick < 65) peer = own;
          end else act = 3'($urandom_range(0, 7));
        end
        send_event(act, peer);
      end
    end

    settle_idle();
    repeat (8) @(negedge clk_i);
    if (mismatches == 0)
      $display("bus_poll_master_slave_protocol test passed");
    else
      $display("bus_poll_master_slave_protocol test failed");
    $finish;
  end

endmodule
